[rtl/mpqh_pkg.sv]
// ----------------------------------------------------------------------------
// mpqh_pkg
// shared constants, types and the crypt table of the string hash engine
// ----------------------------------------------------------------------------
package mpqh_pkg;

	localparam int HASH_W         = 32;
	localparam int BYTE_W         = 8;
	localparam int ROW_LIMIT      = 5;
	localparam int ROW_WORDS      = 256;
	localparam int OUT_FIELDS     = 3;
	localparam int HASH_COUNT_DEF = 3;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [BYTE_W-1:0] BYTE_END        = 8'h00;
	localparam logic [HASH_W-1:0] MIX_FIRST_INIT  = 32'h7FED_7FED;
	localparam logic [HASH_W-1:0] MIX_SECOND_INIT = 32'hEEEE_EEEE;
	localparam logic [HASH_W-1:0] MIX_INC         = 32'd3;

	localparam logic [31:0] GEN_SEED  = 32'h0010_0001;
	localparam logic [31:0] GEN_MUL   = 32'd125;
	localparam logic [31:0] GEN_INC   = 32'd3;
	localparam logic [31:0] GEN_MOD   = 32'h002A_AAAB;
	localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

	typedef logic [ROW_LIMIT-1:0][ROW_WORDS-1:0][HASH_W-1:0] crypt_tbl_t;

	// generator s = (125 s + 3) mod 0x2AAAAB, two outputs per table word
	function automatic crypt_tbl_t build_crypt_table();
		crypt_tbl_t tbl;
		logic [31:0] s;
		logic [31:0] hi;
		logic [31:0] lo;
		tbl = '0;
		s = GEN_SEED;
		for (int col = 0; col < ROW_WORDS; col++) begin
			for (int row = 0; row < ROW_LIMIT; row++) begin
				s = (s * GEN_MUL + GEN_INC) % GEN_MOD;
				hi = (s & HALF_MASK) << 16;
				s = (s * GEN_MUL + GEN_INC) % GEN_MOD;
				lo = s & HALF_MASK;
				tbl[row][col] = hi | lo;
			end
		end
		return tbl;
	endfunction

	localparam crypt_tbl_t CRYPT_TABLE = build_crypt_table();

endpackage

[rtl/mpqh_queue.sv]
// ----------------------------------------------------------------------------
// mpqh_queue
// small register queue with full and empty flags
// ----------------------------------------------------------------------------
module mpqh_queue
	import mpqh_pkg::*;
#(
	parameter int WIDTH = HASH_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[rtl/mpqh_front.sv]
// ----------------------------------------------------------------------------
// mpqh_front
// byte intake: end-of-string classification and crypt table lookup
// ----------------------------------------------------------------------------
module mpqh_front
	import mpqh_pkg::*;
#(
	parameter int HASH_COUNT = HASH_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [BYTE_W-1:0]                   byte_in,
	output logic                                full,
	output logic                                cmd_push,
	output logic                                cmd_is_end,
	output logic [BYTE_W-1:0]                   cmd_byte,
	output logic [HASH_COUNT-1:0][HASH_W-1:0]   cmd_crypt,
	input  logic                                cmd_full
);

	logic                              valid_s1;
	logic                              is_end_s1;
	logic [BYTE_W-1:0]                 byte_s1;
	logic [HASH_COUNT-1:0][HASH_W-1:0] crypt_s1;
	logic                              take;

	// stage holds while the queue behind it is full
	assign full     = valid_s1 && cmd_full;
	assign take     = push && !full;
	assign cmd_push = valid_s1 && !cmd_full;

	assign cmd_is_end = is_end_s1;
	assign cmd_byte   = byte_s1;
	assign cmd_crypt  = crypt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			is_end_s1 <= (byte_in == BYTE_END);
			byte_s1   <= byte_in;
			for (int r = 0; r < HASH_COUNT; r++) begin
				crypt_s1[r] <= CRYPT_TABLE[r][byte_in];
			end
		end
	end

endmodule

[rtl/mpqh_back.sv]
// ----------------------------------------------------------------------------
// mpqh_back
// per-seed mixing lanes; emits the hashes on end of string
// ----------------------------------------------------------------------------
module mpqh_back
	import mpqh_pkg::*;
#(
	parameter int HASH_COUNT = HASH_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	input  logic                              cmd_is_end,
	input  logic [BYTE_W-1:0]                 cmd_byte,
	input  logic [HASH_COUNT-1:0][HASH_W-1:0] cmd_crypt,
	output logic                              cmd_take,
	input  logic                              res_full,
	output logic                              res_push,
	output logic [HASH_COUNT-1:0][HASH_W-1:0] res_hash
);

	logic [HASH_COUNT-1:0][HASH_W-1:0] mix_first_q;
	logic [HASH_COUNT-1:0][HASH_W-1:0] mix_second_q;
	logic [HASH_COUNT-1:0][HASH_W-1:0] first_nxt;
	logic [HASH_COUNT-1:0][HASH_W-1:0] second_nxt;
	logic [HASH_COUNT-1:0][HASH_W-1:0] second_part;
	logic [HASH_W-1:0]                 byte_ext;

	// an end word waits for room in the result queue
	assign cmd_take = cmd_valid && (!cmd_is_end || !res_full);
	assign res_push = cmd_take && cmd_is_end;
	assign res_hash = mix_first_q;
	assign byte_ext = {{(HASH_W - BYTE_W){1'b0}}, cmd_byte};

	always_comb begin
		for (int r = 0; r < HASH_COUNT; r++) begin
			first_nxt[r]   = cmd_crypt[r] ^ (mix_first_q[r] + mix_second_q[r]);
			second_part[r] = mix_second_q[r] + (mix_second_q[r] << 5) + byte_ext + MIX_INC;
			second_nxt[r]  = first_nxt[r] + second_part[r];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < HASH_COUNT; r++) begin
				mix_first_q[r]  <= MIX_FIRST_INIT;
				mix_second_q[r] <= MIX_SECOND_INIT;
			end
		end else if (cmd_take) begin
			for (int r = 0; r < HASH_COUNT; r++) begin
				if (cmd_is_end) begin
					mix_first_q[r]  <= MIX_FIRST_INIT;
					mix_second_q[r] <= MIX_SECOND_INIT;
				end else begin
					mix_first_q[r]  <= first_nxt[r];
					mix_second_q[r] <= second_nxt[r];
				end
			end
		end
	end

endmodule

[rtl/mpq_string_hash_engine.sv]
// throughput: one byte per cycle, held back while the command or result queue is full
// the hashes of a string become readable after its zero byte passes the front lookup register,
// then the command queue, then the mix lanes, which push them into the result queue
// reset: arst_n clears all queues and returns every seed pair to 0x7FED7FED / 0xEEEEEEEE
// ----------------------------------------------------------------------------
// mpq_string_hash_engine
// one-way string hash over seeds 0 .. HASH_COUNT-1, one byte per word
// ----------------------------------------------------------------------------
module mpq_string_hash_engine
	import mpqh_pkg::*;
#(
	parameter int HASH_COUNT = HASH_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] byte_in,
	output logic              empty,
	input  logic              pop,
	output logic [HASH_W-1:0] hash_seed0,
	output logic [HASH_W-1:0] hash_seed1,
	output logic [HASH_W-1:0] hash_seed2
);

	localparam int LANE_W = HASH_COUNT * HASH_W;
	localparam int MID_W  = LANE_W + BYTE_W + 1;

	// front side
	logic                              f_push;
	logic                              f_is_end;
	logic [BYTE_W-1:0]                 f_byte;
	logic [HASH_COUNT-1:0][HASH_W-1:0] f_crypt;

	// command queue between front and back
	logic [MID_W-1:0]                  mid_rd_data;
	logic                              mid_full;
	logic                              mid_empty;

	// back side
	logic                              b_take;
	logic                              b_is_end;
	logic [BYTE_W-1:0]                 b_byte;
	logic [HASH_COUNT-1:0][HASH_W-1:0] b_crypt;
	logic                              res_push;
	logic [HASH_COUNT-1:0][HASH_W-1:0] res_hash;

	// result queue
	logic [LANE_W-1:0]                 out_data;
	logic                              out_full;
	logic [HASH_W-1:0]                 hash_word [OUT_FIELDS];

	// intake stage: flags the terminating zero byte and reads each seed's table row
	mpqh_front #(
		.HASH_COUNT(HASH_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.byte_in   (byte_in),
		.full      (full),
		.cmd_push  (f_push),
		.cmd_is_end(f_is_end),
		.cmd_byte  (f_byte),
		.cmd_crypt (f_crypt),
		.cmd_full  (mid_full)
	);

	// short queue so the intake keeps taking bytes while the back waits on the result side
	mpqh_queue #(
		.WIDTH(MID_W),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (f_push),
		.wr_data({f_crypt, f_byte, f_is_end}),
		.rd_en  (b_take),
		.rd_data(mid_rd_data),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	// unpack command word: lookup words on top, then the byte, end flag at bit 0
	assign b_is_end = mid_rd_data[0];
	assign b_byte   = mid_rd_data[BYTE_W:1];
	assign b_crypt  = mid_rd_data[MID_W-1:BYTE_W+1];

	// mixing lanes, one per seed; a data byte never stalls, an end byte waits for room
	mpqh_back #(
		.HASH_COUNT(HASH_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!mid_empty),
		.cmd_is_end(b_is_end),
		.cmd_byte  (b_byte),
		.cmd_crypt (b_crypt),
		.cmd_take  (b_take),
		.res_full  (out_full),
		.res_push  (res_push),
		.res_hash  (res_hash)
	);

	// result queue doubles as the output register; its head is shown while not empty
	mpqh_queue #(
		.WIDTH(LANE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_hash),
		.rd_en  (pop),
		.rd_data(out_data),
		.full   (out_full),
		.empty  (empty)
	);

	// seeds beyond the configured count read as zero
	for (genvar g = 0; g < OUT_FIELDS; g++) begin : g_out
		if (g < HASH_COUNT) begin : g_act
			assign hash_word[g] = out_data[g*HASH_W +: HASH_W];
		end else begin : g_off
			assign hash_word[g] = '0;
		end
	end

	assign hash_seed0 = hash_word[0];
	assign hash_seed1 = hash_word[1];
	assign hash_seed2 = hash_word[2];

	// a result is only produced when the result queue has room
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !out_full)
		else $error("result pushed into a full result queue");

	// the intake only forwards into a command queue with room
	a_cmd_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !mid_full)
		else $error("command pushed into a full command queue");

	// a finished string is visible on the result side in the following cycle
	a_res_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> !empty)
		else $error("result queue empty after a hash was pushed");

	// a data byte is never held back in the back end
	a_data_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!mid_empty && !b_is_end) |-> b_take)
		else $error("data byte stalled in the mixing lanes");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// string hash engine check: bytes go in as words, per-seed hashes come out on
// each zero byte and are compared field by field with an in-bench predictor
// ----------------------------------------------------------------------------
module testbench;
	import mpqh_pkg::*;

	// seed lanes of the instance under test, with the active row count clamped to 1 .. ROW_LIMIT in the bench
	localparam int LANES       = HASH_COUNT_DEF;
	localparam int ACTIVE_ROWS = (LANES > ROW_LIMIT) ? ROW_LIMIT : ((LANES < 1) ? 1 : LANES);

	localparam int ITEMS_PER_PHASE = 550;
	localparam int HOLD_CYCLES     = 300;
	localparam int STALL_LIMIT     = 3000;
	localparam int TAIL_CYCLES     = 8;

	// one result word: element r is the hash of seed r
	typedef logic [OUT_FIELDS-1:0][HASH_W-1:0] hash_set_t;

	// directed rows: pinned rows carry a typed-in expectation (empty string)
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              pinned;
	} string_byte_t;

	localparam int DIRECTED_ROWS = 23;
	localparam string_byte_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h00, 1'b1},                                   // empty string right after reset
		'{8'h00, 1'b1},                                   // empty string again
		'{8'h41, 1'b0}, '{8'h00, 1'b0},                   // single letter
		'{8'hFF, 1'b0}, '{8'h00, 1'b0},                   // top byte value
		'{8'h01, 1'b0}, '{8'h00, 1'b0},                   // lowest nonzero byte
		'{8'h80, 1'b0}, '{8'h7F, 1'b0}, '{8'h55, 1'b0}, '{8'hAA, 1'b0}, '{8'h00, 1'b0},
		'{8'h61, 1'b0}, '{8'h62, 1'b0}, '{8'h63, 1'b0}, '{8'h00, 1'b0},   // "abc"
		'{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'h00, 1'b0},
		'{8'h00, 1'b1},                                   // empty string after a multi-byte one
		'{8'h00, 1'b1}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic [BYTE_W-1:0] byte_in = '0;
	logic              pop = 1'b0;
	logic              full;
	logic              empty;
	logic [HASH_W-1:0] hash_seed0;
	logic [HASH_W-1:0] hash_seed1;
	logic [HASH_W-1:0] hash_seed2;

	// predictor state: crypt table and one mixing pair per seed
	logic [HASH_W-1:0] crypt_words [ROW_LIMIT][ROW_WORDS];
	logic [HASH_W-1:0] seed_first  [ROW_LIMIT];
	logic [HASH_W-1:0] seed_second [ROW_LIMIT];

	hash_set_t pending_hashes [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req    = 0;
	int items_sent  = 0;
	int mismatches  = 0;

	mpq_string_hash_engine #(
		.HASH_COUNT(LANES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.byte_in    (byte_in),
		.empty      (empty),
		.pop        (pop),
		.hash_seed0 (hash_seed0),
		.hash_seed1 (hash_seed1),
		.hash_seed2 (hash_seed2)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// pairs back to their start values, used on reset and after each zero byte
	function automatic void clear_seed_pairs();
		int r;
		for (r = 0; r < ROW_LIMIT; r++) begin
			seed_first[r]  = MIX_FIRST_INIT;
			seed_second[r] = MIX_SECOND_INIT;
		end
	endfunction

	// advance every active seed by one byte; a zero byte closes the string
	// and hands back the hashes, seeds past the active count read as zero
	function automatic bit hash_byte(input logic [BYTE_W-1:0] b, output hash_set_t hashes);
		logic [HASH_W-1:0] f;
		logic [HASH_W-1:0] s;
		int r;
		hashes = '0;
		if (b == BYTE_END) begin
			for (r = 0; r < OUT_FIELDS; r++)
				if (r < ACTIVE_ROWS)
					hashes[r] = seed_first[r];
			clear_seed_pairs();
			return 1'b1;
		end
		for (r = 0; r < ACTIVE_ROWS; r++) begin
			f = crypt_words[r][b] ^ (seed_first[r] + seed_second[r]);
			s = {{(HASH_W-BYTE_W){1'b0}}, b} + f + seed_second[r] + (seed_second[r] << 5) + MIX_INC;
			seed_first[r]  = f;
			seed_second[r] = s;
		end
		return 1'b0;
	endfunction

	task automatic note_fault(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// offer one byte word, wait for it to be taken, then log what it should cause
	task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic pinned);
		hash_set_t hashes;
		// random sender gap ahead of the word
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		byte_in <= b;
		do
			@(posedge clk);
		while (full);
		items_sent++;
		if (hash_byte(b, hashes))
			pending_hashes.push_back(pinned ? {OUT_FIELDS{MIX_FIRST_INIT}} : hashes);
	endtask

	// stop offering and let every outstanding hash come back
	task automatic drain_results();
		push <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random pops, a long hold-off on request, and the field checks
	always @(posedge clk) begin : rx_side
		hash_set_t want;
		hash_set_t got;
		int hold_left;
		int hold_taken;
		int r;
		if (hold_req != hold_taken) begin
			hold_taken = hold_req;
			hold_left  = HOLD_CYCLES;
		end
		// the result word on the ports is taken at this edge
		if (pop && !empty) begin
			got = {hash_seed2, hash_seed1, hash_seed0};
			if (pending_hashes.size() == 0) begin
				note_fault($sformatf("result with nothing pending: %08h %08h %08h",
					got[0], got[1], got[2]));
			end else begin
				want = pending_hashes.pop_front();
				for (r = 0; r < OUT_FIELDS; r++)
					if (got[r] !== want[r])
						note_fault($sformatf("hash_seed%0d expected %08h got %08h",
							r, want[r], got[r]));
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog: too long without any word moving on either side
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("mpq_string_hash_engine test failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [31:0] gen;
		logic [31:0] hi_half;
		int col;
		int row;
		int phase;
		int phase_start;
		int len;
		int pick;
		int flavor;
		int i;
		logic [BYTE_W-1:0] b;

		// crypt table: two generator steps per word, high half first
		gen = GEN_SEED;
		for (col = 0; col < ROW_WORDS; col++) begin
			for (row = 0; row < ROW_LIMIT; row++) begin
				gen     = (gen * GEN_MUL + GEN_INC) % GEN_MOD;
				hi_half = gen;
				gen     = (gen * GEN_MUL + GEN_INC) % GEN_MOD;
				crypt_words[row][col] = {hi_half[15:0], gen[15:0]};
			end
		end
		clear_seed_pairs();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings, no idling on either side
		for (i = 0; i < DIRECTED_ROWS; i++)
			offer_byte(DIRECTED[i].value, DIRECTED[i].pinned);
		drain_results();

		// random strings in three idling phases; the sender drains between them
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 14;
					rx_idle_pct = 46;
				end
				1: begin
					tx_idle_pct = 46;
					rx_idle_pct = 14;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					// receiver goes quiet while words keep coming, so full must rise
					hold_req++;
				end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < ITEMS_PER_PHASE) begin
				// mostly short strings, some medium, a few long
				pick = $urandom_range(99);
				if (pick < 70)
					len = $urandom_range(8, 0);
				else if (pick < 95)
					len = $urandom_range(32, 9);
				else
					len = $urandom_range(80, 33);
				flavor = $urandom_range(9);
				for (i = 0; i < len; i++) begin
					case (flavor)
						0: b = 8'hFF;
						1: b = 8'h01 << $urandom_range(7);
						default: b = BYTE_W'($urandom_range(255, 1));
					endcase
					offer_byte(b, 1'b0);
				end
				offer_byte(BYTE_END, 1'b0);
			end
			drain_results();
		end

		// idle tail so any stray result word still shows up before the verdict
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("mpq_string_hash_engine test passed");
		else
			$display("mpq_string_hash_engine test failed");
		$finish;
	end

endmodule
